[sv/ple_pkg.sv]
// shared types and codes for the positional list engine
package ple_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 7;
  localparam int CNT_OUT_W    = 7;

  // request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_AMEND  = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BADPOS   = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  // per-cell operation
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_AMEND  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic                at;       // cell sits at the addressed position
    logic                past;     // cell sits after the addressed position
    logic                in_list;  // cell holds a live entry
    logic [VALUE_W-1:0]  value;
  } cell_ctl_t;

endpackage

[sv/ple_cell.sv]
// one storage cell of the list: holds an entry, shifts with its neighbors, compares
module ple_cell (
  input  logic                          clk,
  input  ple_pkg::cell_ctl_t            ctl,
  input  logic [ple_pkg::VALUE_W-1:0]   left_entry,
  input  logic [ple_pkg::VALUE_W-1:0]   right_entry,
  output logic [ple_pkg::VALUE_W-1:0]   entry,
  output logic                          match
);

  logic [ple_pkg::VALUE_W-1:0] entry_r;
  logic [ple_pkg::VALUE_W-1:0] entry_nxt;
  logic                        match_r;
  logic                        match_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      ple_pkg::CELL_INSERT: begin
        if (ctl.at) begin
          entry_nxt = ctl.value;
        end else if (ctl.past) begin
          entry_nxt = left_entry;
        end
      end
      ple_pkg::CELL_DELETE: begin
        if (ctl.at || ctl.past) begin
          entry_nxt = right_entry;
        end
      end
      ple_pkg::CELL_AMEND: begin
        if (ctl.at) begin
          entry_nxt = ctl.value;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
    match_nxt = ctl.in_list && (entry_r == ctl.value);
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

[sv/ple_first_match.sv]
// picks the lowest set match flag and returns its 1-based position
module ple_first_match #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic [CAPACITY-1:0]            match_vec,
  output logic                           any_match,
  output logic [ple_pkg::CNT_OUT_W-1:0]  first_pos
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CAPACITY-1:0] lowest;
  logic [IDX_W-1:0]    match_idx;

  // isolate lowest set bit, then encode the one-hot word
  assign lowest = match_vec & (~match_vec + CAPACITY'(1));

  always_comb begin
    match_idx = '0;
    for (int b = 0; b < IDX_W; b++) begin
      for (int j = 0; j < CAPACITY; j++) begin
        match_idx[b] = match_idx[b] | (lowest[j] & 1'(j >> b));
      end
    end
  end

  assign any_match = |match_vec;
  assign first_pos = ple_pkg::CNT_OUT_W'(CNT_W'(match_idx) + CNT_W'(1));

endmodule

[sv/positional_list_engine_top.sv]
// top level of the positional list engine: control, count and the chain of cells
//
//  channel | direction | fields (low bit first)
//  --------+-----------+--------------------------------------------------
//  in_     | slave     | tdata: req_type[1:0] position[8:2] value[40:9]
//  out_    | master    | tdata: status[1:0] found_position[8:2] entry_count[15:9]
//
// after acceptance a request runs through these steps: apply in all cells
// at once, first-match encode for find, load output register.
// a new request is accepted only once the previous result is loaded and the engine is idle.
// the next request is accepted while a result still waits in the output register.
// reset clears the count and the control; cell contents stay undefined until written.
// a stalled output holds the engine in its last step until the register frees up.
module positional_list_engine_top #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // req_type, position, value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status, found_position, entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SRCH = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]                 count_r, count_nxt;
  ple_pkg::req_t                    req_r, req_nxt;
  logic [ple_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic [ple_pkg::VALUE_W-1:0]      val_r, val_nxt;
  ple_pkg::status_t                 res_status_r, res_status_nxt;
  logic [ple_pkg::CNT_OUT_W-1:0]    res_found_r, res_found_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [15:0]                      out_data_r, out_data_nxt;

  logic [CAPACITY-1:0][ple_pkg::VALUE_W-1:0] entries;
  logic [CAPACITY-1:0]                       match_vec;
  ple_pkg::cell_ctl_t [CAPACITY-1:0]         ctl_vec;

  logic                          any_match;
  logic [ple_pkg::CNT_OUT_W-1:0] first_pos;

  logic [CMP_W-1:0]    pos_ext, cnt_ext;
  ple_pkg::status_t    exec_status;
  ple_pkg::cell_op_t   exec_op;
  logic                in_fire;
  logic                out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(count_r);

  // request checks and the operation the cells carry out
  always_comb begin
    exec_status = ple_pkg::STAT_OK;
    exec_op     = ple_pkg::CELL_HOLD;
    case (req_r)
      ple_pkg::REQ_INSERT: begin
        if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
          exec_status = ple_pkg::STAT_BADPOS;
        end else if (cnt_ext == CMP_W'(CAPACITY)) begin
          exec_status = ple_pkg::STAT_FULL;
        end else begin
          exec_op = ple_pkg::CELL_INSERT;
        end
      end
      ple_pkg::REQ_DELETE: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          exec_status = ple_pkg::STAT_BADPOS;
        end else begin
          exec_op = ple_pkg::CELL_DELETE;
        end
      end
      ple_pkg::REQ_FIND: begin
        exec_status = ple_pkg::STAT_NOTFOUND;
      end
      ple_pkg::REQ_AMEND: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          exec_status = ple_pkg::STAT_BADPOS;
        end else begin
          exec_op = ple_pkg::CELL_AMEND;
        end
      end
      default: begin
        exec_status = ple_pkg::STAT_OK;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [ple_pkg::VALUE_W-1:0] left_entry;
      logic [ple_pkg::VALUE_W-1:0] right_entry;

      if (gi == 0) begin : g_first
        assign left_entry = val_r;
      end else begin : g_mid_l
        assign left_entry = entries[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_entry = entries[gi];
      end else begin : g_mid_r
        assign right_entry = entries[gi+1];
      end

      assign ctl_vec[gi].op      = (state_r == S_EXEC) ? exec_op : ple_pkg::CELL_HOLD;
      assign ctl_vec[gi].at      = (pos_ext == CMP_W'(gi + 1));
      assign ctl_vec[gi].past    = (pos_ext < CMP_W'(gi + 1));
      assign ctl_vec[gi].in_list = (cnt_ext > CMP_W'(gi));
      assign ctl_vec[gi].value   = val_r;

      ple_cell u_cell (
        .clk         (clk),
        .ctl         (ctl_vec[gi]),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .entry       (entries[gi]),
        .match       (match_vec[gi])
      );
    end
  endgenerate

  ple_first_match #(
    .CAPACITY (CAPACITY)
  ) u_first_match (
    .match_vec (match_vec),
    .any_match (any_match),
    .first_pos (first_pos)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    req_nxt        = req_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt   = ple_pkg::req_t'(in_tdata[1:0]);
          pos_nxt   = in_tdata[8:2];
          val_nxt   = in_tdata[40:9];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_nxt = exec_status;
        res_found_nxt  = '0;
        if (exec_op == ple_pkg::CELL_INSERT) begin
          count_nxt = count_r + CNT_W'(1);
        end else if (exec_op == ple_pkg::CELL_DELETE) begin
          count_nxt = count_r - CNT_W'(1);
        end
        // match flags are registered at this edge, encoded next cycle
        state_nxt = (req_r == ple_pkg::REQ_FIND) ? S_SRCH : S_DONE;
      end
      S_SRCH: begin
        if (any_match) begin
          res_status_nxt = ple_pkg::STAT_OK;
          res_found_nxt  = first_pos;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ple_pkg::CNT_OUT_W'(count_r), res_found_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
